// File: hdl/sng_pkg.sv
// ----------------------------------------------------------------------------
// sng_pkg: shared types and constants of the stereo noise gate
// Gain format, register indexes, reset values and the control bundles that
// the sequencer hands to the lanes and the gain unit.
// ----------------------------------------------------------------------------
package sng_pkg;

	// default widths of samples and smoothing coefficients
	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int COEFF_WIDTH_DEF  = 24;

	// gain is unsigned q1.23, unity needs the top bit
	localparam int GAIN_FRAC = 23;
	localparam int GAIN_W    = 24;
	localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1) << GAIN_FRAC;

	// configuration port
	localparam int CFG_W       = 24;
	localparam int CFG_INDEX_W = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CLOSED    = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ATTACK    = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RELEASE   = 4'd3;

	localparam logic [CFG_W-1:0] THRESHOLD_RST = 24'd83886;
	localparam logic [CFG_W-1:0] CLOSED_RST    = 24'd839;
	localparam logic [CFG_W-1:0] ATTACK_RST    = 24'd16742287;
	localparam logic [CFG_W-1:0] RELEASE_RST   = 24'd16773721;

	// per-lane strobes from the sequencer
	typedef struct packed {
		logic load;
		logic mag_en;
		logic mul_en;
	} lane_ctrl_t;

	// gain unit strobes from the sequencer
	typedef struct packed {
		logic tgt_en;
		logic mul_en;
		logic upd_en;
	} gain_ctrl_t;

endpackage

// File: hdl/sng_lane.sv
// ----------------------------------------------------------------------------
// sng_lane: one channel lane
// Holds one sample, finds its magnitude, scales it by the gain and gives the
// rounded, saturated result.
// ----------------------------------------------------------------------------
module sng_lane
	import sng_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  lane_ctrl_t                     ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic [GAIN_W-1:0]              gain,
	output logic [SAMPLE_WIDTH-1:0]        mag,
	output logic signed [SAMPLE_WIDTH-1:0] result
);

	localparam int PW = SAMPLE_WIDTH + GAIN_W + 1;
	localparam logic signed [PW-1:0] HALF = PW'(1) << (GAIN_FRAC - 1);
	localparam logic signed [PW-1:0] HI   = (PW'(1) << (SAMPLE_WIDTH - 1)) - PW'(1);
	localparam logic signed [PW-1:0] LO   = -HI - PW'(1);

	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic [SAMPLE_WIDTH-1:0]        mag_q;
	logic signed [PW-1:0]           prod_q;
	logic [SAMPLE_WIDTH-1:0]        raw;
	logic signed [PW-1:0]           rnd;
	logic signed [PW-1:0]           shifted;

	// magnitude, most negative value maps to 2^(w-1) unsigned
	assign raw = sample_q;

	// sample, magnitude and product registers
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sample_q <= sample;
		end
		if (ctrl.mag_en) begin
			mag_q <= raw[SAMPLE_WIDTH-1] ? (~raw + SAMPLE_WIDTH'(1)) : raw;
		end
		if (ctrl.mul_en) begin
			prod_q <= sample_q * $signed({1'b0, gain});
		end
	end

	// round half up, then clamp to the sample range
	always_comb begin
		rnd     = prod_q + HALF;
		shifted = rnd >>> GAIN_FRAC;
		if (shifted > HI) begin
			result = HI[SAMPLE_WIDTH-1:0];
		end else if (shifted < LO) begin
			result = LO[SAMPLE_WIDTH-1:0];
		end else begin
			result = shifted[SAMPLE_WIDTH-1:0];
		end
	end

	assign mag = mag_q;

endmodule

// File: hdl/sng_gain.sv
// ----------------------------------------------------------------------------
// sng_gain: level merge and gain smoothing
// Combines the lane magnitudes into the level, picks the target and the
// coefficient, and moves the held gain one one-pole step.
// ----------------------------------------------------------------------------
module sng_gain
	import sng_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COEFF_WIDTH  = COEFF_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gain_ctrl_t              ctrl,
	input  logic [SAMPLE_WIDTH-1:0] mag_l,
	input  logic [SAMPLE_WIDTH-1:0] mag_r,
	input  logic [CFG_W-1:0]        threshold_level,
	input  logic [CFG_W-1:0]        closed_gain,
	input  logic [CFG_W-1:0]        attack_coeff,
	input  logic [CFG_W-1:0]        release_coeff,
	output logic [GAIN_W-1:0]       gain
);

	localparam int CMP_W  = (SAMPLE_WIDTH > CFG_W) ? SAMPLE_WIDTH : CFG_W;
	localparam int DIFF_W = GAIN_W + 1;
	localparam int PROD_W = DIFF_W + COEFF_WIDTH + 1;
	localparam int EXT_W  = COEFF_WIDTH + CFG_W;
	localparam logic signed [PROD_W-1:0] COEFF_HALF = PROD_W'(1) << (COEFF_WIDTH - 1);

	logic [GAIN_W-1:0]            gain_q;
	logic [GAIN_W-1:0]            target_q;
	logic [COEFF_WIDTH-1:0]       coeff_q;
	logic signed [DIFF_W-1:0]     diff_q;
	logic signed [PROD_W-1:0]     prod_q;

	logic [SAMPLE_WIDTH-1:0]      level;
	logic [GAIN_W-1:0]            floor_gain;
	logic [GAIN_W-1:0]            target_d;
	logic [EXT_W-1:0]             coeff_ext;
	logic signed [PROD_W-1:0]     rnd;
	logic signed [PROD_W-1:0]     step;
	logic signed [PROD_W-1:0]     sum;

	// merge the lanes, choose target and coefficient
	always_comb begin
		level      = (mag_l > mag_r) ? mag_l : mag_r;
		floor_gain = (closed_gain > GAIN_UNITY) ? GAIN_UNITY : closed_gain;
		target_d   = (CMP_W'(level) >= CMP_W'(threshold_level)) ? GAIN_UNITY : floor_gain;
		coeff_ext  = EXT_W'((target_d > gain_q) ? attack_coeff : release_coeff);
	end

	// rounded step towards the target
	always_comb begin
		rnd  = prod_q + COEFF_HALF;
		step = rnd >>> COEFF_WIDTH;
		sum  = $signed(PROD_W'(target_q)) + step;
	end

	// merge and multiply registers
	always_ff @(posedge clk) begin
		if (ctrl.tgt_en) begin
			target_q <= target_d;
			coeff_q  <= coeff_ext[COEFF_WIDTH-1:0];
			diff_q   <= $signed({1'b0, gain_q}) - $signed({1'b0, target_d});
		end
		if (ctrl.mul_en) begin
			prod_q <= diff_q * $signed({1'b0, coeff_q});
		end
	end

	// held gain, muted after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
		end else if (ctrl.upd_en) begin
			gain_q <= sum[GAIN_W-1:0];
		end
	end

	assign gain = gain_q;

endmodule

// File: hdl/stereo_noise_gate.sv
// ----------------------------------------------------------------------------
// stereo_noise_gate: stereo noise gate with attack and release smoothing
// Gates a stereo stream by a smoothed gain that opens on the louder channel.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one stereo pair per transfer, m_* one gated pair per transfer.
//   cfg_* writes one register per transfer (index 0 threshold, 1 closed gain,
//   2 attack coefficient, 3 release coefficient); other indexes are ignored.
//   cfg_ready is always high; write only while the stream is idle.
// Sequencing:
//   a pair is worked on by a sequencer over capture, magnitude, merge,
//   coefficient multiply, gain update, scale and output load. The sequencer
//   handles one pair at a time and takes the next only once back in idle.
// Stalls:
//   the result waits in the output register while the next pair is taken
//   and worked on; the sequencer holds in its last step until that register
//   is free.
// Reset:
//   registers return to their defaults, gain is zero (muted), no result is
//   pending.
// ----------------------------------------------------------------------------
module stereo_noise_gate
	import sng_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	parameter int COEFF_WIDTH  = COEFF_WIDTH_DEF,
	localparam int DATA_W      = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [DATA_W-1:0]      s_tdata,   // left_sample, right_sample
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [DATA_W-1:0]      m_tdata,   // left_out, right_out
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MAG  = 7'b0000010,
		ST_TGT  = 7'b0000100,
		ST_MUL  = 7'b0001000,
		ST_UPD  = 7'b0010000,
		ST_SCL  = 7'b0100000,
		ST_SAT  = 7'b1000000
	} state_t;

	state_t                   state_q;
	state_t                   state_d;
	logic [CFG_W-1:0]         threshold_q;
	logic [CFG_W-1:0]         closed_q;
	logic [CFG_W-1:0]         attack_q;
	logic [CFG_W-1:0]         release_q;
	logic                     m_tvalid_q;
	logic [SAMPLE_WIDTH-1:0]  left_out_q;
	logic [SAMPLE_WIDTH-1:0]  right_out_q;

	lane_ctrl_t               lane_ctrl;
	gain_ctrl_t               gain_ctrl;
	logic                     in_xfer;
	logic                     out_free;
	logic                     out_load;
	logic [SAMPLE_WIDTH-1:0]  mag_l;
	logic [SAMPLE_WIDTH-1:0]  mag_r;
	logic signed [SAMPLE_WIDTH-1:0] res_l;
	logic signed [SAMPLE_WIDTH-1:0] res_r;
	logic [GAIN_W-1:0]        gain;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign out_load  = (state_q == ST_SAT) && out_free;

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_xfer) state_d = ST_MAG;
			ST_MAG:  state_d = ST_TGT;
			ST_TGT:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_UPD;
			ST_UPD:  state_d = ST_SCL;
			ST_SCL:  state_d = ST_SAT;
			ST_SAT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// strobes to the lanes and the gain unit
	always_comb begin
		lane_ctrl.load   = in_xfer;
		lane_ctrl.mag_en = (state_q == ST_MAG);
		lane_ctrl.mul_en = (state_q == ST_SCL);
		gain_ctrl.tgt_en = (state_q == ST_TGT);
		gain_ctrl.mul_en = (state_q == ST_MUL);
		gain_ctrl.upd_en = (state_q == ST_UPD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			closed_q    <= CLOSED_RST;
			attack_q    <= ATTACK_RST;
			release_q   <= RELEASE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_THRESHOLD: threshold_q <= cfg_data;
				REG_CLOSED:    closed_q    <= cfg_data;
				REG_ATTACK:    attack_q    <= cfg_data;
				REG_RELEASE:   release_q   <= cfg_data;
				default:       ;
			endcase
		end
	end

	// left and right lanes
	sng_lane #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_lane_l (
		.clk    (clk),
		.ctrl   (lane_ctrl),
		.sample (s_tdata[SAMPLE_WIDTH-1:0]),
		.gain   (gain),
		.mag    (mag_l),
		.result (res_l)
	);

	sng_lane #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_lane_r (
		.clk    (clk),
		.ctrl   (lane_ctrl),
		.sample (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
		.gain   (gain),
		.mag    (mag_r),
		.result (res_r)
	);

	// level merge and gain smoothing
	sng_gain #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.COEFF_WIDTH (COEFF_WIDTH)
	) u_gain (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (gain_ctrl),
		.mag_l           (mag_l),
		.mag_r           (mag_r),
		.threshold_level (threshold_q),
		.closed_gain     (closed_q),
		.attack_coeff    (attack_q),
		.release_coeff   (release_q),
		.gain            (gain)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			left_out_q  <= res_l;
			right_out_q <= res_r;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DATA_W'({right_out_q, left_out_q});

endmodule

// File: hdl/sng_checker.sv
// ----------------------------------------------------------------------------
// sng_checker: port-level checks of the stereo noise gate
// Watches the stream ports for sequencer spacing and output holding.
// ----------------------------------------------------------------------------
module sng_checker
	import sng_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	localparam int DATA_W      = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata
);

	// after a pair is taken, the input is not ready while it is in work
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready)
		else $error("input taken again while a pair is in work");

	// a new result appears only as the sequencer returns to idle
	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result loaded while the sequencer stays busy");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("output transfer dropped or changed under stall");

endmodule

bind stereo_noise_gate sng_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_sng_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
